FILE: rtl/core/mdel_pkg.sv
package mdel_pkg;

	localparam int LEVEL_W        = 9;
	localparam int TIME_W         = 32;
	localparam int FILT_W         = 16;
	localparam int OP_W           = 2;
	localparam int CH_W           = 4;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 16;
	localparam int NUM_INPUTS_DEF = 9;
	localparam int CMD_FIFO_DEPTH = 2;

	localparam logic [FILT_W-1:0] FILTER_TIME_RESET = FILT_W'(50);

	localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd0;
	localparam logic [OP_W-1:0] OP_GET_RISE = 2'd1;
	localparam logic [OP_W-1:0] OP_GET_FALL = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 1'b1;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_SAMPLE,
		CMD_GET_RISE,
		CMD_GET_FALL,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [CH_W-1:0]     channel;
		logic [LEVEL_W-1:0]  pins;
		logic [TIME_W-1:0]   now;
	} cmd_t;

endpackage

FILE: rtl/core/mdel_fifo.sv
module mdel_fifo #(
	parameter int DEPTH = mdel_pkg::CMD_FIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  mdel_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output logic          valid,
	output mdel_pkg::cmd_t rd_data
);
	import mdel_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && valid;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/mdel_front.sv
module mdel_front #(
	parameter int NUM_INPUTS = mdel_pkg::NUM_INPUTS_DEF
) (
	input  logic                         push,
	output logic                         full,
	input  logic [mdel_pkg::OP_W-1:0]    operation,
	input  logic [mdel_pkg::LEVEL_W-1:0] pin_levels,
	input  logic [mdel_pkg::TIME_W-1:0]  now_ms,
	input  logic [mdel_pkg::CH_W-1:0]    channel,
	input  logic                         cmd_full,
	output logic                         cmd_we,
	output mdel_pkg::cmd_t               cmd
);
	import mdel_pkg::*;

	logic in_range;

	// out-of-range channel turns a flag operation into a no-op
	assign in_range = ({1'b0, channel} < (CH_W + 1)'(NUM_INPUTS));
	assign full     = cmd_full;
	assign cmd_we   = push;

	always_comb begin
		cmd.channel = channel;
		cmd.pins    = pin_levels;
		cmd.now     = now_ms;
		case (operation)
			OP_SAMPLE:   cmd.kind = CMD_SAMPLE;
			OP_GET_RISE: cmd.kind = in_range ? CMD_GET_RISE : CMD_NOP;
			OP_GET_FALL: cmd.kind = in_range ? CMD_GET_FALL : CMD_NOP;
			OP_CLEAR:    cmd.kind = in_range ? CMD_CLEAR : CMD_NOP;
			default:     cmd.kind = CMD_NOP;
		endcase
	end

endmodule

FILE: rtl/core/mdel_back.sv
module mdel_back #(
	parameter int NUM_INPUTS = mdel_pkg::NUM_INPUTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mdel_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mdel_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              cmd_valid,
	input  mdel_pkg::cmd_t                    cmd,
	output logic                              cmd_rd,
	output logic                              empty,
	input  logic                              pop,
	output logic [mdel_pkg::LEVEL_W-1:0]      filtered_levels,
	output logic                              edge_seen
);
	import mdel_pkg::*;

	localparam int EXT_W = (NUM_INPUTS > LEVEL_W) ? NUM_INPUTS : LEVEL_W;

	logic [FILT_W-1:0]     filter_q;
	logic [LEVEL_W-1:0]    invert_q;
	logic [NUM_INPUTS-1:0] raw_q;
	logic [TIME_W-1:0]     stamp_q [NUM_INPUTS];
	logic [NUM_INPUTS-1:0] filt_q;
	logic [NUM_INPUTS-1:0] rise_q;
	logic [NUM_INPUTS-1:0] fall_q;

	logic [NUM_INPUTS-1:0] raw_nxt;
	logic [TIME_W-1:0]     stamp_nxt [NUM_INPUTS];
	logic [NUM_INPUTS-1:0] filt_nxt;
	logic [NUM_INPUTS-1:0] rise_nxt;
	logic [NUM_INPUTS-1:0] fall_nxt;
	logic                  seen_nxt;

	logic [EXT_W-1:0]      pins_ext;
	logic [EXT_W-1:0]      inv_ext;
	logic [EXT_W-1:0]      lv_ext;

	logic                  out_valid_q;
	logic [LEVEL_W-1:0]    out_levels_q;
	logic                  out_seen_q;
	logic                  advance;

	assign advance         = cmd_valid && (!out_valid_q || pop);
	assign cmd_rd          = advance;
	assign empty           = !out_valid_q;
	assign filtered_levels = out_levels_q;
	assign edge_seen       = out_seen_q;

	assign pins_ext = EXT_W'(cmd.pins);
	assign inv_ext  = EXT_W'(invert_q);
	assign lv_ext   = EXT_W'(filt_nxt);

	always_comb begin
		logic [TIME_W-1:0] age;
		logic              sel;
		raw_nxt  = raw_q;
		filt_nxt = filt_q;
		rise_nxt = rise_q;
		fall_nxt = fall_q;
		seen_nxt = 1'b0;
		for (int c = 0; c < NUM_INPUTS; c++) begin
			stamp_nxt[c] = stamp_q[c];
			age = cmd.now - stamp_q[c];
			sel = (cmd.channel == CH_W'(c));
			case (cmd.kind)
				CMD_SAMPLE: begin
					if (pins_ext[c] != raw_q[c]) begin
						raw_nxt[c]   = pins_ext[c];
						stamp_nxt[c] = cmd.now;
					end else if (age > TIME_W'(filter_q)) begin
						filt_nxt[c] = raw_q[c] ^ inv_ext[c];
					end
					if (!filt_nxt[c] && filt_q[c]) begin
						fall_nxt[c] = 1'b1;
					end else if (filt_nxt[c] && !filt_q[c]) begin
						rise_nxt[c] = 1'b1;
					end
				end
				CMD_GET_RISE: begin
					if (sel) begin
						seen_nxt    = rise_q[c];
						rise_nxt[c] = 1'b0;
					end
				end
				CMD_GET_FALL: begin
					if (sel) begin
						seen_nxt    = fall_q[c];
						fall_nxt[c] = 1'b0;
					end
				end
				CMD_CLEAR: begin
					if (sel) begin
						rise_nxt[c] = 1'b0;
						fall_nxt[c] = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= FILTER_TIME_RESET;
			invert_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FILTER_TIME: filter_q <= cfg_data;
				CFG_INVERT_MASK: invert_q <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q  <= '0;
			filt_q <= '0;
			rise_q <= '0;
			fall_q <= '0;
			for (int c = 0; c < NUM_INPUTS; c++) begin
				stamp_q[c] <= '0;
			end
		end else if (advance) begin
			raw_q  <= raw_nxt;
			filt_q <= filt_nxt;
			rise_q <= rise_nxt;
			fall_q <= fall_nxt;
			for (int c = 0; c < NUM_INPUTS; c++) begin
				stamp_q[c] <= stamp_nxt[c];
			end
		end
	end

	// result word register; refilled in the same cycle it is popped when a command waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_levels_q <= lv_ext[LEVEL_W-1:0];
			out_seen_q   <= seen_nxt;
		end
	end

endmodule

FILE: rtl/core/multi_input_debounce_edge_latch_core.sv
// A pushed word is written into the command queue, then processed into the result register.
// Throughput: one word per cycle while results are popped; the result register refills in the cycle it is popped.
// full rises only when the two-entry command queue holds two words while the result waits.
// Reset (arst_n low, asynchronous): filter time 50 ms, invert mask 0, all channel
// state and flags cleared, command queue and result register empty.
module multi_input_debounce_edge_latch_core #(
	parameter int NUM_INPUTS = mdel_pkg::NUM_INPUTS_DEF,
	parameter int CMD_DEPTH  = mdel_pkg::CMD_FIFO_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mdel_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mdel_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            push,
	output logic                            full,
	input  logic [mdel_pkg::OP_W-1:0]       operation,
	input  logic [mdel_pkg::LEVEL_W-1:0]    pin_levels,
	input  logic [mdel_pkg::TIME_W-1:0]     now_ms,
	input  logic [mdel_pkg::CH_W-1:0]       channel,
	output logic                            empty,
	input  logic                            pop,
	output logic [mdel_pkg::LEVEL_W-1:0]    filtered_levels,
	output logic                            edge_seen
);
	import mdel_pkg::*;

	cmd_t front_cmd;
	cmd_t back_cmd;
	logic front_we;
	logic cmd_full;
	logic cmd_valid;
	logic cmd_rd;

	mdel_front #(
		.NUM_INPUTS (NUM_INPUTS)
	) u_front (
		.push       (push),
		.full       (full),
		.operation  (operation),
		.pin_levels (pin_levels),
		.now_ms     (now_ms),
		.channel    (channel),
		.cmd_full   (cmd_full),
		.cmd_we     (front_we),
		.cmd        (front_cmd)
	);

	mdel_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_we),
		.wr_data (front_cmd),
		.full    (cmd_full),
		.rd_en   (cmd_rd),
		.valid   (cmd_valid),
		.rd_data (back_cmd)
	);

	mdel_back #(
		.NUM_INPUTS (NUM_INPUTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd_valid       (cmd_valid),
		.cmd             (back_cmd),
		.cmd_rd          (cmd_rd),
		.empty           (empty),
		.pop             (pop),
		.filtered_levels (filtered_levels),
		.edge_seen       (edge_seen)
	);

endmodule
